// ----- hdl/igs_pkg.sv -----
package igs_pkg;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } igs_op_t;

  localparam logic [31:0] ONE_Q31 = 32'h8000_0000;
  localparam logic [63:0] ONE_Q32 = 64'h0000_0001_0000_0000;

  typedef struct packed {
    igs_op_t     op;
    logic [2:0]  dim_index;
    logic [5:0]  bin_select;
    logic [31:0] boundary;
    logic [31:0] random;
    logic        last_dim;
  } igs_item_t;

  typedef struct packed {
    logic [31:0] sample_coord;
    logic [5:0]  bin_index;
    logic [63:0] weight;
    logic        event_done;
  } igs_result_t;

endpackage

// ----- hdl/igs_ram.sv -----
module igs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/igs_queue.sv -----
module igs_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int PW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full    = count == CW'(DEPTH);
  assign empty   = count == '0;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (!push && pop) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

// ----- hdl/igs_front.sv -----
module igs_front #(
  parameter int DIMS = 8,
  parameter int BINS = 64,
  localparam int BW = $clog2(BINS),
  localparam int AW = $clog2(DIMS * BINS),
  localparam int EW = 36 + BW + 2 * AW
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  igs_pkg::igs_item_t   item,
  output logic                 q_push,
  input  logic                 q_full,
  output logic [EW-1:0]        q_data
);

  typedef struct packed {
    igs_pkg::igs_op_t op;
    logic             dim0;
    logic             last;
    logic             clamp;
    logic [BW-1:0]    bin;
    logic [31:0]      data;
    logic [AW-1:0]    addr_hi;
    logic [AW-1:0]    addr_lo;
  } entry_t;

  logic            valid;
  entry_t          ent;
  entry_t          ent_next;
  logic            accept;
  logic            keep;
  logic            dim_ok;
  logic            bin_ok;
  logic [31:0]     u;
  logic [31+BW:0]  scaled;
  logic [BW-1:0]   bin;
  logic [AW+2:0]   base;
  logic [AW+2:0]   addr;

  assign full   = valid && q_full;
  assign accept = push && !full;
  assign q_push = valid && !q_full;
  assign q_data = ent;

  always_comb begin
    dim_ok = 6'(item.dim_index) < 6'(DIMS);
    bin_ok = 11'(item.bin_select) < 11'(BINS);
    u      = ~item.random + 32'd1;
    scaled = (32 + BW)'(u) * (32 + BW)'(BINS);
    ent_next      = '0;
    ent_next.op   = item.op;
    ent_next.dim0 = item.dim_index == 3'd0;
    ent_next.last = item.last_dim;
    if (item.op == igs_pkg::OP_SAMPLE) begin
      keep           = dim_ok;
      ent_next.clamp = item.random == '0;
      bin            = ent_next.clamp ? BW'(BINS - 1) : scaled[31+BW:32];
      ent_next.data  = scaled[31:0];
    end else begin
      keep           = dim_ok && bin_ok;
      ent_next.clamp = 1'b0;
      bin            = BW'(item.bin_select);
      ent_next.data  = (item.boundary > igs_pkg::ONE_Q31) ? igs_pkg::ONE_Q31 : item.boundary;
    end
    ent_next.bin     = bin;
    base             = (AW + 3)'(item.dim_index) * (AW + 3)'(BINS);
    addr             = base + (AW + 3)'(bin);
    ent_next.addr_hi = addr[AW-1:0];
    ent_next.addr_lo = (bin == '0) ? addr[AW-1:0] : addr[AW-1:0] - AW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (accept) begin
      valid <= keep;
    end else if (q_push) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ent <= ent_next;
    end
  end

endmodule

// ----- hdl/igs_back.sv -----
module igs_back #(
  parameter int DIMS = 8,
  parameter int BINS = 64,
  localparam int BW = $clog2(BINS),
  localparam int AW = $clog2(DIMS * BINS),
  localparam int EW = 36 + BW + 2 * AW
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_empty,
  input  logic [EW-1:0]        q_data,
  output logic                 q_pop,
  input  logic                 oq_full,
  output logic                 oq_push,
  output igs_pkg::igs_result_t oq_data
);

  localparam int FW = 33 + BW;
  localparam int PW = 64 + FW;

  typedef struct packed {
    igs_pkg::igs_op_t op;
    logic             dim0;
    logic             last;
    logic             clamp;
    logic [BW-1:0]    bin;
    logic [31:0]      data;
    logic [AW-1:0]    addr_hi;
    logic [AW-1:0]    addr_lo;
  } entry_t;

  entry_t          head;
  logic            adv;
  logic            wr_en;
  logic [31:0]     hi_rd;
  logic [31:0]     lo_rd;

  logic            s1_valid;
  logic            s1_dim0;
  logic            s1_last;
  logic            s1_clamp;
  logic [BW-1:0]   s1_bin;
  logic [31:0]     s1_frac;

  logic            s2_valid;
  logic            s2_dim0;
  logic            s2_last;
  logic            s2_clamp;
  logic [BW-1:0]   s2_bin;
  logic [31:0]     s2_frac;
  logic [31:0]     s2_lo;
  logic [31:0]     s2_hi;
  logic            s2_neg;
  logic [31:0]     s2_d;

  logic            s3_valid;
  logic            s3_dim0;
  logic            s3_last;
  logic            s3_clamp;
  logic [BW-1:0]   s3_bin;
  logic [31:0]     s3_lo;
  logic [31:0]     s3_hi;
  logic            s3_neg;
  logic [31:0]     s3_prod;
  logic [FW-1:0]   s3_factor;
  logic            s3_fin;

  logic [1:0]      step;
  logic [PW-1:0]   acc;
  logic [63:0]     weight_acc;

  logic [31:0]     lo_val;
  logic            neg_n;
  logic [31:0]     d_n;
  logic [63:0]     prod;
  logic [FW-1:0]   factor_n;
  logic [31:0]     a_part;
  logic [31:0]     f_part;
  logic [63:0]     pp;
  logic [PW-1:0]   pp_sh;
  logic [PW-1:0]   sum;
  logic [63:0]     w_new;

  assign head  = entry_t'(q_data);
  assign adv   = !s3_valid || s3_fin;
  assign q_pop = adv && !q_empty;
  assign wr_en = q_pop && head.op == igs_pkg::OP_WRITE;

  // two copies of the grid so that both bin edges are read in the same cycle
  igs_ram #(
    .WIDTH (32),
    .DEPTH (DIMS * BINS)
  ) u_hi_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (head.addr_hi),
    .wdata (head.data),
    .re    (q_pop),
    .raddr (head.addr_hi),
    .rdata (hi_rd)
  );

  igs_ram #(
    .WIDTH (32),
    .DEPTH (DIMS * BINS)
  ) u_lo_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (head.addr_hi),
    .wdata (head.data),
    .re    (q_pop),
    .raddr (head.addr_lo),
    .rdata (lo_rd)
  );

  always_comb begin
    lo_val   = (s1_bin == '0) ? '0 : lo_rd;
    neg_n    = hi_rd < lo_val;
    d_n      = neg_n ? lo_val - hi_rd : hi_rd - lo_val;
    prod     = {32'b0, s2_d} * {32'b0, s2_frac};
    factor_n = s2_neg ? '0 : FW'(s2_d) * FW'(2 * BINS);
  end

  // weight times factor in four 32x32 partial products
  always_comb begin
    a_part = step[1] ? weight_acc[63:32] : weight_acc[31:0];
    f_part = step[0] ? 32'(s3_factor[FW-1:32]) : s3_factor[31:0];
    pp     = {32'b0, a_part} * {32'b0, f_part};
    case (step)
      2'd0:       pp_sh = PW'(pp);
      2'd1, 2'd2: pp_sh = PW'(pp) << 32;
      default:    pp_sh = PW'(pp) << 64;
    endcase
    sum = acc + pp_sh;
    if (s3_dim0) begin
      w_new = 64'(s3_factor);
    end else if (|sum[PW-1:96]) begin
      w_new = '1;
    end else begin
      w_new = sum[95:32];
    end
  end

  assign s3_fin  = s3_valid && (s3_dim0 || step == 2'd3) && !oq_full;
  assign oq_push = s3_fin;

  always_comb begin
    oq_data.bin_index  = 6'(s3_bin);
    oq_data.weight     = w_new;
    oq_data.event_done = s3_last;
    if (s3_clamp) begin
      oq_data.sample_coord = s3_hi;
    end else if (s3_neg) begin
      oq_data.sample_coord = s3_lo - s3_prod;
    end else begin
      oq_data.sample_coord = s3_lo + s3_prod;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
      s3_valid   <= 1'b0;
      step       <= '0;
      weight_acc <= igs_pkg::ONE_Q32;
    end else begin
      if (adv) begin
        s1_valid <= q_pop && head.op == igs_pkg::OP_SAMPLE;
        s2_valid <= s1_valid;
        s3_valid <= s2_valid;
        step     <= '0;
      end else if (s3_valid && step != 2'd3) begin
        step <= step + 2'd1;
      end
      if (s3_fin) begin
        weight_acc <= w_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_dim0   <= head.dim0;
      s1_last   <= head.last;
      s1_clamp  <= head.clamp;
      s1_bin    <= head.bin;
      s1_frac   <= head.data;
      s2_dim0   <= s1_dim0;
      s2_last   <= s1_last;
      s2_clamp  <= s1_clamp;
      s2_bin    <= s1_bin;
      s2_frac   <= s1_frac;
      s2_lo     <= lo_val;
      s2_hi     <= hi_rd;
      s2_neg    <= neg_n;
      s2_d      <= d_n;
      s3_dim0   <= s2_dim0;
      s3_last   <= s2_last;
      s3_clamp  <= s2_clamp;
      s3_bin    <= s2_bin;
      s3_lo     <= s2_lo;
      s3_hi     <= s2_hi;
      s3_neg    <= s2_neg;
      s3_prod   <= prod[63:32];
      s3_factor <= factor_n;
      acc       <= '0;
    end else if (step != 2'd3) begin
      acc <= sum;
    end
  end

endmodule

// ----- hdl/importance_grid_sampler.sv -----
// Path: a sample's result passes the front register, the command queue, stages s1 to s3 and
// the result queue; grid writes give no result.
// Throughput: one item per cycle for grid writes and dimension-0 samples unless a full queue stalls;
// any other sample holds stage s3 and the shared 32x32 weight multiplier (64-bit weight times bin factor).
// Reset: rst empties both queues and the pipeline and sets the weight to one; grid entries
// are undefined until written.
module importance_grid_sampler #(
  parameter int DIMS = 8,
  parameter int BINS = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  igs_pkg::igs_item_t   item,
  output logic                 empty,
  input  logic                 pop,
  output igs_pkg::igs_result_t result
);

  localparam int BW = $clog2(BINS);
  localparam int AW = $clog2(DIMS * BINS);
  localparam int EW = 36 + BW + 2 * AW;
  localparam int RW = $bits(igs_pkg::igs_result_t);

  logic                 q_push;
  logic                 q_full;
  logic                 q_empty;
  logic                 q_pop;
  logic [EW-1:0]        q_wdata;
  logic [EW-1:0]        q_rdata;
  logic                 oq_push;
  logic                 oq_full;
  igs_pkg::igs_result_t oq_data;

  igs_front #(
    .DIMS (DIMS),
    .BINS (BINS)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .q_push (q_push),
    .q_full (q_full),
    .q_data (q_wdata)
  );

  igs_queue #(
    .WIDTH (EW),
    .DEPTH (4)
  ) u_cmd_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (q_wdata),
    .pop     (q_pop),
    .rd_data (q_rdata),
    .full    (q_full),
    .empty   (q_empty)
  );

  igs_back #(
    .DIMS (DIMS),
    .BINS (BINS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (q_rdata),
    .q_pop   (q_pop),
    .oq_full (oq_full),
    .oq_push (oq_push),
    .oq_data (oq_data)
  );

  igs_queue #(
    .WIDTH (RW),
    .DEPTH (2)
  ) u_out_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (oq_push),
    .wr_data (oq_data),
    .pop     (pop && !empty),
    .rd_data (result),
    .full    (oq_full),
    .empty   (empty)
  );

`ifndef SYNTH
  a_cmd_no_overflow: assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("command queue written while full");
  a_out_no_overflow: assert property (@(posedge clk) disable iff (rst) oq_push |-> !oq_full)
    else $error("result queue written while full");
  a_empty_after_rst: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");
`endif

endmodule
